// ===== design/cbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrt_pkg: shared types and constants of the Bezier ribbon tessellator
// Datapath commands, controller states, status bundle and register indexes.
// ----------------------------------------------------------------------------
package cbrt_pkg;

  localparam int SegmentsDef = 40;
  localparam int IdxW        = 6;
  localparam int CfgIdxW     = 8;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 240;
  localparam int OutDataW    = 136;

  localparam logic signed [15:0] ClipLeftRst   = 16'sd0;
  localparam logic signed [15:0] ClipRightRst  = 16'sd8192;
  localparam logic signed [15:0] ClipTopRst    = 16'sd0;
  localparam logic signed [15:0] ClipBottomRst = 16'sd8192;

  localparam logic [CfgIdxW-1:0] CfgClipLeft   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgClipRight  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgClipTop    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgClipBottom = 8'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_UU, OP_TT, OP_W0, OP_W1, OP_W2, OP_W3, OP_ACC, OP_PNT,
    OP_DIFF, OP_SQX, OP_SQY, OP_NORM, OP_SQI, OP_SQS, OP_DVI, OP_DVS, OP_DVE,
    OP_HX, OP_HY, OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {TS_FWD, TS_CEN, TS_BWD} tsel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_UU, S_TT, S_W0, S_W1, S_W2, S_W3, S_ACC, S_PNT, S_DIFF, S_SQX,
    S_SQY, S_NORM, S_SQI, S_SQS, S_DVI, S_DVS, S_DVE, S_HX, S_HY, S_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e          op;
    tsel_e           tsel;
    logic [1:0]      k;
    logic            sel_y;
    logic [IdxW-1:0] idx;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic clip_empty;
    logic n2_zero;
    logic norm_done;
    logic sq_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/cubic_bezier_ribbon_tessellator.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_ribbon_tessellator: cubic Bezier to ribbon vertex pairs
// One curve in, SEGMENTS+1 vertex pairs out, or none for an empty clip.
// ----------------------------------------------------------------------------
// Per point: Bezier evaluation, a shift search that normalizes the squared tangent,
// the 32-step square root and the two bit-serial divides (root and divides skipped
// for a zero tangent); evaluation and half-width products share one multiplier.
// Output stalls hold the sequencer in its emit state.
// One curve at a time; a new one is taken once the last pair is registered.
// Reset: clip rectangle returns to (0,0)-(8192,8192); no clearing pass.
module cubic_bezier_ribbon_tessellator #(
  parameter int SEGMENTS = cbrt_pkg::SegmentsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbrt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbrt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
  // width, rgba
  input  logic [cbrt_pkg::InDataW-1:0]  s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // point_index, left_x, left_y, right_x, right_y, vertex_color, 2'b0
  output logic [cbrt_pkg::OutDataW-1:0] m_tdata_o,
  output logic                          m_tlast_o
);

  cbrt_pkg::cmd_t cmd;
  cbrt_pkg::sts_t sts;

  cbrt_ctrl #(.SEGMENTS(SEGMENTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbrt_dp #(.SEGMENTS(SEGMENTS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

// ===== design/cbrt_dp.sv =====
// ----------------------------------------------------------------------------
// cbrt_dp: tessellator datapath
// Shared multiplier, curve window, iterative sqrt and divider, output register.
// ----------------------------------------------------------------------------
module cbrt_dp #(
  parameter int SEGMENTS = cbrt_pkg::SegmentsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbrt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbrt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [cbrt_pkg::InDataW-1:0]  in_data_i,
  input  cbrt_pkg::cmd_t                cmd_i,
  output cbrt_pkg::sts_t                sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [cbrt_pkg::OutDataW-1:0] m_tdata_o,
  output logic                          m_tlast_o
);

  localparam int TQ = 65536 / SEGMENTS;
  localparam int TR = 65536 % SEGMENTS;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) return 24'sh7FFFFF;
    else if (v < -28'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  logic signed [15:0] cl_q, cr_q, ct_q, cb_q;
  logic signed [23:0] px_q [4];
  logic signed [23:0] py_q [4];
  logic [15:0]        wd_q;
  logic [31:0]        color_q;
  logic [16:0]        tq_q;
  logic [5:0]         tr_q;
  logic [33:0]        uu_q, tt_q;
  logic [16:0]        wt_q [4];
  logic signed [43:0] accx_q, accy_q;
  logic signed [23:0] wx_q [3];
  logic signed [23:0] wy_q [3];
  logic signed [23:0] cx_q, cy_q;
  logic signed [24:0] dx_q, dy_q;
  logic [61:0]        n_q;
  logic [4:0]         sh_q;
  logic [61:0]        rem_q;
  logic [63:0]        res_q;
  logic [4:0]         j_q;
  logic [46:0]        drem_q, dd_q;
  logic [16:0]        dq_q;
  logic [4:0]         dk_q;
  logic               dneg_q;
  logic signed [17:0] ux_q, uy_q;
  logic signed [19:0] hx_q, hy_q;
  logic               ov_q, ol_q;
  logic [cbrt_pkg::OutDataW-1:0] od_q;

  // shared multiplier
  logic [16:0]        u_w;
  logic [35:0]        uu3_w, tt3_w;
  logic signed [36:0] ma;
  logic signed [24:0] mb;
  logic signed [61:0] prod;
  logic signed [61:0] prnd32, prnd16;
  logic signed [43:0] ptx_t, pty_t;
  logic signed [23:0] ptx, pty;
  logic [6:0]         trs;
  logic [63:0]        bitv, trial;
  logic signed [24:0] dv;
  logic [24:0]        mag;
  logic [30:0]        lroot;
  logic [17:0]        uval;
  logic signed [23:0] lx, ly, rx, ry;
  logic               out_free;

  assign u_w   = 17'h10000 - tq_q;
  assign uu3_w = {1'b0, uu_q, 1'b0} + {2'b0, uu_q};
  assign tt3_w = {1'b0, tt_q, 1'b0} + {2'b0, tt_q};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      cbrt_pkg::OP_UU: begin ma = $signed({20'd0, u_w}); mb = $signed({8'd0, u_w}); end
      cbrt_pkg::OP_TT: begin ma = $signed({20'd0, tq_q}); mb = $signed({8'd0, tq_q}); end
      cbrt_pkg::OP_W0: begin ma = $signed({3'd0, uu_q}); mb = $signed({8'd0, u_w}); end
      cbrt_pkg::OP_W1: begin ma = $signed({1'b0, uu3_w}); mb = $signed({8'd0, tq_q}); end
      cbrt_pkg::OP_W2: begin ma = $signed({1'b0, tt3_w}); mb = $signed({8'd0, u_w}); end
      cbrt_pkg::OP_W3: begin ma = $signed({3'd0, tt_q}); mb = $signed({8'd0, tq_q}); end
      cbrt_pkg::OP_ACC: begin
        ma = $signed({20'd0, wt_q[cmd_i.k]});
        mb = cmd_i.sel_y ? 25'(py_q[cmd_i.k]) : 25'(px_q[cmd_i.k]);
      end
      cbrt_pkg::OP_SQX: begin ma = 37'(dx_q); mb = dx_q; end
      cbrt_pkg::OP_SQY: begin ma = 37'(dy_q); mb = dy_q; end
      cbrt_pkg::OP_HX:  begin ma = -37'(uy_q); mb = $signed({9'd0, wd_q}); end
      cbrt_pkg::OP_HY:  begin ma = 37'(ux_q); mb = $signed({9'd0, wd_q}); end
      default: ;
    endcase
  end

  assign prod   = 62'(ma) * 62'(mb);
  assign prnd32 = prod + 62'sd2147483648;
  assign prnd16 = prod + 62'sd32768;

  assign ptx_t = accx_q + 44'sd32768;
  assign pty_t = accy_q + 44'sd32768;
  assign ptx   = sat24(ptx_t[43:16]);
  assign pty   = sat24(pty_t[43:16]);
  assign trs   = {1'b0, tr_q} + 7'(TR);

  assign bitv  = 64'd1 << {j_q, 1'b0};
  assign trial = res_q + bitv;

  assign dv    = cmd_i.sel_y ? dy_q : dx_q;
  assign mag   = dv[24] ? 25'(-dv) : 25'(dv);
  assign lroot = res_q[30:0];
  assign uval  = dneg_q ? 18'(-{1'b0, dq_q}) : {1'b0, dq_q};

  assign lx = sat24(28'(cx_q) + 28'(hx_q));
  assign ly = sat24(28'(cy_q) + 28'(hy_q));
  assign rx = sat24(28'(cx_q) - 28'(hx_q));
  assign ry = sat24(28'(cy_q) - 28'(hy_q));

  assign out_free = !ov_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q <= cbrt_pkg::ClipLeftRst;
      cr_q <= cbrt_pkg::ClipRightRst;
      ct_q <= cbrt_pkg::ClipTopRst;
      cb_q <= cbrt_pkg::ClipBottomRst;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cbrt_pkg::CfgClipLeft:   cl_q <= cfg_data_i;
          cbrt_pkg::CfgClipRight:  cr_q <= cfg_data_i;
          cbrt_pkg::CfgClipTop:    ct_q <= cfg_data_i;
          cbrt_pkg::CfgClipBottom: cb_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == cbrt_pkg::OP_EMIT && out_free) ov_q <= 1'b1;
      else if (m_tready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cbrt_pkg::OP_LOAD: begin
        for (int k = 0; k < 4; k++) begin
          px_q[k] <= in_data_i[48*k +: 24];
          py_q[k] <= in_data_i[48*k+24 +: 24];
        end
        wd_q    <= in_data_i[207:192];
        color_q <= in_data_i[239:208];
        tq_q    <= '0;
        tr_q    <= 6'(SEGMENTS / 2);
      end
      cbrt_pkg::OP_UU: uu_q <= prod[33:0];
      cbrt_pkg::OP_TT: tt_q <= prod[33:0];
      cbrt_pkg::OP_W0: wt_q[0] <= prnd32[48:32];
      cbrt_pkg::OP_W1: wt_q[1] <= prnd32[48:32];
      cbrt_pkg::OP_W2: wt_q[2] <= prnd32[48:32];
      cbrt_pkg::OP_W3: wt_q[3] <= prnd32[48:32];
      cbrt_pkg::OP_ACC: begin
        if (cmd_i.sel_y) accy_q <= ((cmd_i.k == 2'd0) ? 44'sd0 : accy_q) + 44'(prod);
        else             accx_q <= ((cmd_i.k == 2'd0) ? 44'sd0 : accx_q) + 44'(prod);
      end
      cbrt_pkg::OP_PNT: begin
        wx_q[0] <= wx_q[1]; wx_q[1] <= wx_q[2]; wx_q[2] <= ptx;
        wy_q[0] <= wy_q[1]; wy_q[1] <= wy_q[2]; wy_q[2] <= pty;
        // t = round(i * 65536 / SEGMENTS), kept as quotient and remainder
        if (trs >= 7'(SEGMENTS)) begin
          tr_q <= 6'(trs - 7'(SEGMENTS));
          tq_q <= tq_q + 17'(TQ + 1);
        end else begin
          tr_q <= trs[5:0];
          tq_q <= tq_q + 17'(TQ);
        end
      end
      cbrt_pkg::OP_DIFF: begin
        dx_q <= 25'(wx_q[2]) - 25'((cmd_i.tsel == cbrt_pkg::TS_CEN) ? wx_q[0] : wx_q[1]);
        dy_q <= 25'(wy_q[2]) - 25'((cmd_i.tsel == cbrt_pkg::TS_CEN) ? wy_q[0] : wy_q[1]);
        cx_q <= (cmd_i.tsel == cbrt_pkg::TS_BWD) ? wx_q[2] : wx_q[1];
        cy_q <= (cmd_i.tsel == cbrt_pkg::TS_BWD) ? wy_q[2] : wy_q[1];
      end
      cbrt_pkg::OP_SQX: n_q <= prod;
      cbrt_pkg::OP_SQY: begin
        n_q  <= n_q + 62'(prod);
        sh_q <= '0;
      end
      cbrt_pkg::OP_NORM: begin
        if (n_q == '0) begin
          ux_q <= '0;
          uy_q <= '0;
        end else if (n_q[61:60] == 2'b00) begin
          n_q  <= n_q << 2;
          sh_q <= sh_q + 5'd1;
        end
      end
      cbrt_pkg::OP_SQI: begin
        rem_q <= n_q;
        res_q <= '0;
        j_q   <= 5'd31;
      end
      cbrt_pkg::OP_SQS: begin
        if ({2'b00, rem_q} >= trial) begin
          rem_q <= rem_q - 62'(trial);
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
        j_q <= j_q - 5'd1;
      end
      cbrt_pkg::OP_DVI: begin
        // numerator fits 47 bits: |d| << sh stays below 2^31
        drem_q <= (47'(mag) << (6'(sh_q) + 6'd15)) + 47'(lroot >> 1);
        dd_q   <= 47'(lroot) << 16;
        dq_q   <= '0;
        dk_q   <= 5'd16;
        dneg_q <= dv[24];
      end
      cbrt_pkg::OP_DVS: begin
        if (drem_q >= dd_q) begin
          drem_q <= drem_q - dd_q;
          dq_q   <= {dq_q[15:0], 1'b1};
        end else begin
          dq_q   <= {dq_q[15:0], 1'b0};
        end
        dd_q <= dd_q >> 1;
        dk_q <= dk_q - 5'd1;
      end
      cbrt_pkg::OP_DVE: begin
        if (cmd_i.sel_y) uy_q <= uval;
        else             ux_q <= uval;
      end
      cbrt_pkg::OP_HX: hx_q <= prnd16[35:16];
      cbrt_pkg::OP_HY: hy_q <= prnd16[35:16];
      cbrt_pkg::OP_EMIT: begin
        if (out_free) begin
          od_q <= {2'b00, color_q, ry, rx, ly, lx, cmd_i.idx};
          ol_q <= cmd_i.last;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.clip_empty = (cr_q <= cl_q) || (cb_q <= ct_q);
  assign sts_o.n2_zero    = (n_q == '0);
  assign sts_o.norm_done  = (n_q[61:60] != 2'b00);
  assign sts_o.sq_last    = (j_q == 5'd0);
  assign sts_o.div_last   = (dk_q == 5'd0);
  assign sts_o.out_free   = out_free;

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = od_q;
  assign m_tlast_o  = ol_q;

  a_sqrt_normed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cbrt_pkg::OP_SQI) |-> (n_q[61:60] != 2'b00))
    else $error("sqrt started on unnormalized operand");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cbrt_pkg::OP_DVI) |-> (res_q[63:31] == '0 && res_q[30]))
    else $error("root outside [2^30, 2^31)");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cbrt_pkg::OP_EMIT && out_free) |=> m_tvalid_o)
    else $error("emitted item not presented");

endmodule

// ===== design/cbrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbrt_ctrl: tessellator sequencer
// Steps the datapath through evaluation, normalization and output per point.
// ----------------------------------------------------------------------------
module cbrt_ctrl #(
  parameter int SEGMENTS = cbrt_pkg::SegmentsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  cbrt_pkg::sts_t sts_i,
  output cbrt_pkg::cmd_t cmd_o
);

  cbrt_pkg::ctl_state_e state_q, state_d;
  logic [cbrt_pkg::IdxW-1:0] i_q, i_d;
  logic [2:0] cnt_q, cnt_d;
  logic       first_q, first_d;
  logic       sely_q, sely_d;
  logic       acc;
  logic       last_pt;

  assign s_tready_o = (state_q == cbrt_pkg::S_IDLE);
  assign acc        = s_tvalid_i && s_tready_o;
  assign last_pt    = (i_q == cbrt_pkg::IdxW'(SEGMENTS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbrt_pkg::S_IDLE: if (acc && !sts_i.clip_empty) state_d = cbrt_pkg::S_UU;
      cbrt_pkg::S_UU:   state_d = cbrt_pkg::S_TT;
      cbrt_pkg::S_TT:   state_d = cbrt_pkg::S_W0;
      cbrt_pkg::S_W0:   state_d = cbrt_pkg::S_W1;
      cbrt_pkg::S_W1:   state_d = cbrt_pkg::S_W2;
      cbrt_pkg::S_W2:   state_d = cbrt_pkg::S_W3;
      cbrt_pkg::S_W3:   state_d = cbrt_pkg::S_ACC;
      cbrt_pkg::S_ACC:  if (cnt_q == 3'd7) state_d = cbrt_pkg::S_PNT;
      cbrt_pkg::S_PNT:  state_d = first_q ? cbrt_pkg::S_UU : cbrt_pkg::S_DIFF;
      cbrt_pkg::S_DIFF: state_d = cbrt_pkg::S_SQX;
      cbrt_pkg::S_SQX:  state_d = cbrt_pkg::S_SQY;
      cbrt_pkg::S_SQY:  state_d = cbrt_pkg::S_NORM;
      cbrt_pkg::S_NORM: begin
        if (sts_i.n2_zero) state_d = cbrt_pkg::S_HX;
        else if (sts_i.norm_done) state_d = cbrt_pkg::S_SQI;
      end
      cbrt_pkg::S_SQI:  state_d = cbrt_pkg::S_SQS;
      cbrt_pkg::S_SQS:  if (sts_i.sq_last) state_d = cbrt_pkg::S_DVI;
      cbrt_pkg::S_DVI:  state_d = cbrt_pkg::S_DVS;
      cbrt_pkg::S_DVS:  if (sts_i.div_last) state_d = cbrt_pkg::S_DVE;
      cbrt_pkg::S_DVE:  state_d = sely_q ? cbrt_pkg::S_HX : cbrt_pkg::S_DVI;
      cbrt_pkg::S_HX:   state_d = cbrt_pkg::S_HY;
      cbrt_pkg::S_HY:   state_d = cbrt_pkg::S_EMIT;
      cbrt_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          if (last_pt) state_d = cbrt_pkg::S_IDLE;
          else if (i_q + 6'd1 == cbrt_pkg::IdxW'(SEGMENTS)) state_d = cbrt_pkg::S_DIFF;
          else state_d = cbrt_pkg::S_UU;
        end
      end
      default: state_d = cbrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = cbrt_pkg::OP_NONE;
    cmd_o.tsel  = (i_q == '0) ? cbrt_pkg::TS_FWD :
                  (last_pt ? cbrt_pkg::TS_BWD : cbrt_pkg::TS_CEN);
    cmd_o.idx   = i_q;
    cmd_o.last  = last_pt;
    cmd_o.sel_y = sely_q;
    cmd_o.k     = cnt_q[2:1];
    i_d         = i_q;
    cnt_d       = '0;
    first_d     = first_q;
    sely_d      = sely_q;
    unique case (state_q)
      cbrt_pkg::S_IDLE: begin
        if (acc) begin
          cmd_o.op = cbrt_pkg::OP_LOAD;
          i_d      = '0;
          first_d  = 1'b1;
          sely_d   = 1'b0;
        end
      end
      cbrt_pkg::S_UU:   cmd_o.op = cbrt_pkg::OP_UU;
      cbrt_pkg::S_TT:   cmd_o.op = cbrt_pkg::OP_TT;
      cbrt_pkg::S_W0:   cmd_o.op = cbrt_pkg::OP_W0;
      cbrt_pkg::S_W1:   cmd_o.op = cbrt_pkg::OP_W1;
      cbrt_pkg::S_W2:   cmd_o.op = cbrt_pkg::OP_W2;
      cbrt_pkg::S_W3:   cmd_o.op = cbrt_pkg::OP_W3;
      cbrt_pkg::S_ACC: begin
        // x and y products interleave over the four control points
        cmd_o.op    = cbrt_pkg::OP_ACC;
        cmd_o.sel_y = cnt_q[0];
        cnt_d       = cnt_q + 3'd1;
      end
      cbrt_pkg::S_PNT: begin
        cmd_o.op = cbrt_pkg::OP_PNT;
        first_d  = 1'b0;
      end
      cbrt_pkg::S_DIFF: cmd_o.op = cbrt_pkg::OP_DIFF;
      cbrt_pkg::S_SQX:  cmd_o.op = cbrt_pkg::OP_SQX;
      cbrt_pkg::S_SQY:  cmd_o.op = cbrt_pkg::OP_SQY;
      cbrt_pkg::S_NORM: cmd_o.op = cbrt_pkg::OP_NORM;
      cbrt_pkg::S_SQI:  cmd_o.op = cbrt_pkg::OP_SQI;
      cbrt_pkg::S_SQS:  cmd_o.op = cbrt_pkg::OP_SQS;
      cbrt_pkg::S_DVI:  cmd_o.op = cbrt_pkg::OP_DVI;
      cbrt_pkg::S_DVS:  cmd_o.op = cbrt_pkg::OP_DVS;
      cbrt_pkg::S_DVE: begin
        cmd_o.op = cbrt_pkg::OP_DVE;
        sely_d   = !sely_q;
      end
      cbrt_pkg::S_HX:   cmd_o.op = cbrt_pkg::OP_HX;
      cbrt_pkg::S_HY:   cmd_o.op = cbrt_pkg::OP_HY;
      cbrt_pkg::S_EMIT: begin
        cmd_o.op = cbrt_pkg::OP_EMIT;
        if (sts_i.out_free && !last_pt) i_d = i_q + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbrt_pkg::S_IDLE;
      i_q     <= '0;
      cnt_q   <= '0;
      first_q <= 1'b0;
      sely_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      sely_q  <= sely_d;
    end
  end

  a_empty_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && sts_i.clip_empty) |=> (state_q == cbrt_pkg::S_IDLE))
    else $error("empty clip started a curve");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbrt_pkg::S_EMIT && sts_i.out_free && last_pt) |=>
    (state_q == cbrt_pkg::S_IDLE))
    else $error("no return to idle after last point");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cbrt_pkg::S_IDLE) |-> (i_q <= cbrt_pkg::IdxW'(SEGMENTS)))
    else $error("point index overran");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cubic Bezier ribbon tessellator
// Drives curves on the input stream, predicts every ribbon vertex pair in
// fixed point and compares the output stream item by item, under random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumPts = cbrt_pkg::SegmentsDef + 1;

  typedef struct {
    logic [23:0] px [4];
    logic [23:0] py [4];
    logic [15:0] width;
    logic [31:0] rgba;
  } curve_t;

  typedef struct {
    logic [5:0]  idx;
    logic [23:0] lx, ly, rx, ry;
    logic [31:0] color;
    logic        last;
  } vpair_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [cbrt_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [cbrt_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          s_tvalid_i = 1'b0;
  logic                          s_tready_o;
  logic [cbrt_pkg::InDataW-1:0]  s_tdata_i = '0;
  logic                          m_tvalid_o;
  logic                          m_tready_i = 1'b0;
  logic [cbrt_pkg::OutDataW-1:0] m_tdata_o;
  logic                          m_tlast_o;

  vpair_t           pair_q [$];
  logic signed [15:0] clip_rect [4];
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;
  int               burst_left = 0;
  int               n_errors = 0;
  int               n_curves = 0;
  int               n_pairs = 0;
  int               n_empty = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cubic_bezier_ribbon_tessellator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // ---------------- fixed-point predictor ----------------
  function automatic longint rnd_sh(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // unit tangent in Q1.15, zero vector stays zero
  function automatic void unit_tangent(longint dx, longint dy, output longint ux,
                                       output longint uy);
    longint unsigned n2, l;
    int s;
    n2 = dx * dx + dy * dy;
    ux = 0;
    uy = 0;
    if (n2 == 0) return;
    s = 0;
    while (s + 2 < 64 && (n2 << (s + 2)) < (64'd1 << 62)) s += 2;
    l = isqrt(n2 << s);
    ux = div_near(dx * (longint'(1) <<< (s / 2 + 15)), l);
    uy = div_near(dy * (longint'(1) <<< (s / 2 + 15)), l);
  endfunction

  task automatic predict_ribbon(curve_t c);
    longint sx [NumPts];
    longint sy [NumPts];
    longint wt [4];
    longint ax, ay, ux, uy, hx, hy, w;
    longint unsigned t, u;
    int a, b;
    vpair_t v;
    if (clip_rect[1] <= clip_rect[0] || clip_rect[3] <= clip_rect[2]) begin
      n_empty++;
      return;
    end
    w = longint'(c.width);
    for (int i = 0; i < NumPts; i++) begin
      t = (longint'(i) * 65536 + cbrt_pkg::SegmentsDef / 2) / cbrt_pkg::SegmentsDef;
      u = 65536 - t;
      wt[0] = (u * u * u + (64'd1 << 31)) >> 32;
      wt[1] = (3 * u * u * t + (64'd1 << 31)) >> 32;
      wt[2] = (3 * u * t * t + (64'd1 << 31)) >> 32;
      wt[3] = (t * t * t + (64'd1 << 31)) >> 32;
      ax = 0;
      ay = 0;
      for (int k = 0; k < 4; k++) begin
        ax += wt[k] * longint'($signed(c.px[k]));
        ay += wt[k] * longint'($signed(c.py[k]));
      end
      sx[i] = sat24(rnd_sh(ax, 16));
      sy[i] = sat24(rnd_sh(ay, 16));
    end
    for (int i = 0; i < NumPts; i++) begin
      a = (i == 0) ? 0 : i - 1;
      b = (i == cbrt_pkg::SegmentsDef) ? cbrt_pkg::SegmentsDef : i + 1;
      unit_tangent(sx[b] - sx[a], sy[b] - sy[a], ux, uy);
      hx = rnd_sh(-uy * w, 16);
      hy = rnd_sh(ux * w, 16);
      v.idx   = i[5:0];
      v.lx    = 24'(sat24(sx[i] + hx));
      v.ly    = 24'(sat24(sy[i] + hy));
      v.rx    = 24'(sat24(sx[i] - hx));
      v.ry    = 24'(sat24(sy[i] - hy));
      v.color = c.rgba;
      v.last  = (i == cbrt_pkg::SegmentsDef);
      pair_q = {pair_q, v};
    end
  endtask

  // ---------------- output side ----------------
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      m_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      m_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      burst_left <= $urandom_range(0, 5);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %h, actual %h", name, exp, act);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    vpair_t e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pair_q.size() == 0) begin
        $error("vertex pair with none expected: tdata %h", m_tdata_o);
        n_errors++;
      end else begin
        e = pair_q.pop_front();
        n_pairs++;
        check_field("point_index", 32'(e.idx), 32'(m_tdata_o[5:0]));
        check_field("left_x", 32'(e.lx), 32'(m_tdata_o[29:6]));
        check_field("left_y", 32'(e.ly), 32'(m_tdata_o[53:30]));
        check_field("right_x", 32'(e.rx), 32'(m_tdata_o[77:54]));
        check_field("right_y", 32'(e.ry), 32'(m_tdata_o[101:78]));
        check_field("vertex_color", e.color, m_tdata_o[133:102]);
        check_field("last", 32'(e.last), 32'(m_tlast_o));
      end
    end
  end

  // ---------------- input side ----------------
  task automatic write_reg(logic [cbrt_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= cbrt_pkg::CfgClipBottom) clip_rect[idx[1:0]] = val;
  endtask

  task automatic set_clip(int l, int r, int t, int b);
    write_reg(cbrt_pkg::CfgClipLeft, 16'(l));
    write_reg(cbrt_pkg::CfgClipRight, 16'(r));
    write_reg(cbrt_pkg::CfgClipTop, 16'(t));
    write_reg(cbrt_pkg::CfgClipBottom, 16'(b));
  endtask

  // valid stays high between back-to-back items; only a gap or settle_idle lowers it
  task automatic send_curve(curve_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {c.rgba, c.width, c.py[3], c.px[3], c.py[2], c.px[2],
                   c.py[1], c.px[1], c.py[0], c.px[0]};
    do @(posedge clk_i); while (!s_tready_o);
    n_curves++;
    predict_ribbon(c);
  endtask

  task automatic settle_idle();
    s_tvalid_i <= 1'b0;
    wait (pair_q.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic curve_t flat_curve(logic [23:0] x, logic [23:0] y, logic [15:0] w,
                                        logic [31:0] col);
    curve_t c;
    for (int k = 0; k < 4; k++) begin
      c.px[k] = x;
      c.py[k] = y;
    end
    c.width = w;
    c.rgba  = col;
    return c;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 24'($urandom());
      1:       return $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 4095))
                                           : 24'(24'h800000 + $urandom_range(0, 4095));
      default: return 24'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    for (int k = 0; k < 4; k++) begin
      c.px[k] = rand_coord();
      c.py[k] = rand_coord();
    end
    // occasional repeated control point gives a zero derivative at the start
    if ($urandom_range(0, 9) == 0) begin
      c.px[1] = c.px[0];
      c.py[1] = c.py[0];
    end
    c.width = 16'($urandom());
    c.rgba  = $urandom();
    return c;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    curve_t c;
    send_curve(flat_curve(24'h0, 24'h0, 16'hFFFF, 32'h0));
    send_curve(flat_curve(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 32'hFFFFFFFF));
    send_curve(flat_curve(24'h800000, 24'h800000, 16'hFFFF, 32'hA5A55A5A));
    c = flat_curve(24'h0, 24'h0, 16'h0100, 32'h12345678);
    c.px[1] = 24'd2560; c.px[2] = 24'd5120; c.px[3] = 24'd7680;
    send_curve(c);
    c.width = 16'h0;
    send_curve(c);
    c = flat_curve(24'h800000, 24'h800000, 16'hFFFF, 32'h0F0F0F0F);
    c.px[1] = 24'h7FFFFF; c.py[2] = 24'h7FFFFF;
    c.px[3] = 24'h7FFFFF; c.py[3] = 24'h7FFFFF;
    send_curve(c);
    c = flat_curve(24'h7FFFF0, 24'h800010, 16'hFFFF, 32'hF0F0F0F0);
    c.py[1] = 24'h7FFFF0; c.px[2] = 24'h800010;
    send_curve(c);
    // cusp: inner control points cross over the ends
    c = flat_curve(24'h0, 24'h0, 16'h0800, 32'h00FF00FF);
    c.px[1] = 24'd25600; c.py[1] = 24'd25600;
    c.px[2] = -24'sd25600; c.py[2] = 24'd25600;
    c.px[3] = 24'd0; c.py[3] = 24'd1;
    send_curve(c);
    // one-LSB curve: tiny tangents
    c = flat_curve(24'h0, 24'h0, 16'h8000, 32'hFF00FF00);
    c.px[3] = 24'd1;
    send_curve(c);
    settle_idle();
  endtask

  task automatic test_clip_regs();
    set_clip(100, 100, 0, 8192);
    send_curve(rand_curve());
    send_curve(rand_curve());
    settle_idle();
    set_clip(0, 8192, 5, -5);
    send_curve(rand_curve());
    settle_idle();
    // out-of-range register index must leave the rectangle alone
    write_reg(8'hFF, 16'h0000);
    write_reg(8'h04, 16'hFFFF);
    set_clip(-32768, 32767, -32768, 32767);
    send_curve(rand_curve());
    settle_idle();
    set_clip(32767, -32768, 32767, -32768);
    send_curve(rand_curve());
    settle_idle();
    set_clip(-1, 0, -1, 0);
    send_curve(rand_curve());
    settle_idle();
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    hold_req = 1'b1;
    repeat (4) send_curve(rand_curve());
    settle_idle();
  endtask

  task automatic test_random(int n);
    for (int j = 0; j < n; j++) send_curve(rand_curve());
    settle_idle();
  endtask

  initial begin
    clip_rect[0] = cbrt_pkg::ClipLeftRst;
    clip_rect[1] = cbrt_pkg::ClipRightRst;
    clip_rect[2] = cbrt_pkg::ClipTopRst;
    clip_rect[3] = cbrt_pkg::ClipBottomRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_clip_regs();
    test_backpressure();
    test_random(90);
    set_clip($urandom_range(0, 100) - 200, $urandom_range(1, 30000),
             -32768, $urandom_range(1, 32767));
    test_random(90);
    calm = 1'b1;
    test_random(30);
    $display("Covered %0d curves (%0d with empty clip), %0d vertex pairs checked,",
             n_curves, n_empty, n_pairs);
    $display("clip extremes, ignored register index and a long output stall.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
